>>> sv/bubble_sort_engine_defines.svh
// Assertion macros shared by the bubble sort engine checker.
`ifndef BUBBLE_SORT_ENGINE_DEFINES_SVH
`define BUBBLE_SORT_ENGINE_DEFINES_SVH

// Property checked on every clock edge outside reset.
`define BSE_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) prop) \
        else $error("bubble sort engine check failed");

// Property checked on every clock edge, reset included.
`define BSE_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("bubble sort engine reset check failed");

`endif

>>> sv/bse_pkg.sv
// Package for the bubble sort engine: sizes, control word, microprogram.
`timescale 1ns / 1ps
package bse_pkg;

    localparam int DEPTH = 16;
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int DATA_W = 16;
    localparam int UPC_W = 4;

    // read address select
    localparam logic [1:0] RD_ZERO = 2'd0;
    localparam logic [1:0] RD_K1   = 2'd1;
    localparam logic [1:0] RD_K2   = 2'd2;

    // datapath actions
    localparam logic [3:0] ACT_NONE     = 4'd0;
    localparam logic [3:0] ACT_LOAD     = 4'd1;
    localparam logic [3:0] ACT_PASS_CLR = 4'd2;
    localparam logic [3:0] ACT_K_CLR    = 4'd3;
    localparam logic [3:0] ACT_HOLD     = 4'd4;
    localparam logic [3:0] ACT_CMP      = 4'd5;
    localparam logic [3:0] ACT_PASS_END = 4'd6;
    localparam logic [3:0] ACT_OUT      = 4'd7;
    localparam logic [3:0] ACT_CLEAR    = 4'd8;

    // jump conditions
    localparam logic [2:0] JC_NEVER         = 3'd0;
    localparam logic [2:0] JC_ALWAYS        = 3'd1;
    localparam logic [2:0] JC_NOT_ACC_FINAL = 3'd2;
    localparam logic [2:0] JC_K1_GE_N       = 3'd3;
    localparam logic [2:0] JC_K2_LT_N       = 3'd4;
    localparam logic [2:0] JC_PASS1_LT_N    = 3'd5;
    localparam logic [2:0] JC_NOT_M_ACC     = 3'd6;
    localparam logic [2:0] JC_K_LT_N        = 3'd7;

    // step addresses
    localparam logic [UPC_W-1:0] UA_LOAD       = 4'd0;
    localparam logic [UPC_W-1:0] UA_PASS_INIT  = 4'd1;
    localparam logic [UPC_W-1:0] UA_PASS_START = 4'd2;
    localparam logic [UPC_W-1:0] UA_FIRST      = 4'd3;
    localparam logic [UPC_W-1:0] UA_CMP        = 4'd4;
    localparam logic [UPC_W-1:0] UA_PASS_END   = 4'd5;
    localparam logic [UPC_W-1:0] UA_OUT_INIT   = 4'd6;
    localparam logic [UPC_W-1:0] UA_OUT_LOAD   = 4'd7;
    localparam logic [UPC_W-1:0] UA_OUT_WAIT   = 4'd8;
    localparam logic [UPC_W-1:0] UA_OUT_NEXT   = 4'd9;
    localparam logic [UPC_W-1:0] UA_DONE       = 4'd10;

    typedef struct packed {
        logic             in_ready;
        logic             rd_en;
        logic [1:0]       rd_sel;
        logic [3:0]       act;
        logic [2:0]       cond;
        logic [UPC_W-1:0] target;
    } ctrl_word_t;

    typedef struct packed {
        logic acc_final;
        logic m_acc;
        logic k1_ge_n;
        logic k2_lt_n;
        logic pass1_lt_n;
        logic k_lt_n;
    } dp_flags_t;

    function automatic ctrl_word_t ucode(input logic [UPC_W-1:0] upc);
        ctrl_word_t w;
        w = '{in_ready: 1'b0, rd_en: 1'b0, rd_sel: RD_ZERO, act: ACT_NONE,
              cond: JC_ALWAYS, target: UA_LOAD};
        unique case (upc)
            UA_LOAD: begin
                w.in_ready = 1'b1;
                w.act = ACT_LOAD;
                w.cond = JC_NOT_ACC_FINAL;
                w.target = UA_LOAD;
            end
            UA_PASS_INIT: begin
                w.act = ACT_PASS_CLR;
                w.cond = JC_NEVER;
            end
            UA_PASS_START: begin
                w.act = ACT_K_CLR;
                w.rd_en = 1'b1;
                w.rd_sel = RD_ZERO;
                w.cond = JC_NEVER;
            end
            UA_FIRST: begin
                w.act = ACT_HOLD;
                w.rd_en = 1'b1;
                w.rd_sel = RD_K1;
                w.cond = JC_K1_GE_N;
                w.target = UA_PASS_END;
            end
            UA_CMP: begin
                w.act = ACT_CMP;
                w.rd_en = 1'b1;
                w.rd_sel = RD_K2;
                w.cond = JC_K2_LT_N;
                w.target = UA_CMP;
            end
            UA_PASS_END: begin
                w.act = ACT_PASS_END;
                w.cond = JC_PASS1_LT_N;
                w.target = UA_PASS_START;
            end
            UA_OUT_INIT: begin
                w.act = ACT_K_CLR;
                w.rd_en = 1'b1;
                w.rd_sel = RD_ZERO;
                w.cond = JC_NEVER;
            end
            UA_OUT_LOAD: begin
                w.act = ACT_OUT;
                w.rd_en = 1'b1;
                w.rd_sel = RD_K1;
                w.cond = JC_NEVER;
            end
            UA_OUT_WAIT: begin
                w.cond = JC_NOT_M_ACC;
                w.target = UA_OUT_WAIT;
            end
            UA_OUT_NEXT: begin
                w.cond = JC_K_LT_N;
                w.target = UA_OUT_LOAD;
            end
            UA_DONE: begin
                w.act = ACT_CLEAR;
                w.cond = JC_ALWAYS;
                w.target = UA_LOAD;
            end
            default: begin
                w.cond = JC_ALWAYS;
                w.target = UA_LOAD;
            end
        endcase
        return w;
    endfunction

endpackage

>>> sv/bubble_sort_engine.sv
// Top level of the bubble sort engine.
`timescale 1ns / 1ps
// Loads up to DEPTH signed 16-bit values, one per input beat, and on the
// beat marked final sorts them ascending (stable) and sends them out, the
// last result flagged end_of_list and every result flagged dropped if the
// list overran capacity. Sorting with n stored elements runs n passes of a
// loop over a memory with one read and one write port; output holds each
// result until m_ready takes it before the next is read out. No input is
// taken from the final beat until the last result of that list has been
// sent. Control comes from an eleven-step microprogram.
module bubble_sort_engine (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic signed [bse_pkg::DATA_W-1:0] s_element,
    input  logic                              s_final_req,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic signed [bse_pkg::DATA_W-1:0] m_sorted_value,
    output logic                              m_end_of_list,
    output logic                              m_dropped
);

    bse_pkg::ctrl_word_t ctrl;
    bse_pkg::dp_flags_t  flags;

    bse_sequencer u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .flags   (flags),
        .ctrl    (ctrl)
    );

    bse_datapath u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .ctrl           (ctrl),
        .flags          (flags),
        .s_valid        (s_valid),
        .s_element      (s_element),
        .s_final_req    (s_final_req),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_sorted_value (m_sorted_value),
        .m_end_of_list  (m_end_of_list),
        .m_dropped      (m_dropped)
    );

    assign s_ready = ctrl.in_ready;

endmodule

>>> sv/bse_sequencer.sv
// Step counter, control store lookup and conditional jumps.
`timescale 1ns / 1ps
module bse_sequencer (
    input  logic                aclk,
    input  logic                aresetn,
    input  bse_pkg::dp_flags_t  flags,
    output bse_pkg::ctrl_word_t ctrl
);

    logic [bse_pkg::UPC_W-1:0] upc_reg;
    logic [bse_pkg::UPC_W-1:0] upc_next;
    logic                      take;

    assign ctrl = bse_pkg::ucode(upc_reg);

    always_comb begin
        case (ctrl.cond)
            bse_pkg::JC_NEVER:         take = 1'b0;
            bse_pkg::JC_ALWAYS:        take = 1'b1;
            bse_pkg::JC_NOT_ACC_FINAL: take = !flags.acc_final;
            bse_pkg::JC_K1_GE_N:       take = flags.k1_ge_n;
            bse_pkg::JC_K2_LT_N:       take = flags.k2_lt_n;
            bse_pkg::JC_PASS1_LT_N:    take = flags.pass1_lt_n;
            bse_pkg::JC_NOT_M_ACC:     take = !flags.m_acc;
            bse_pkg::JC_K_LT_N:        take = flags.k_lt_n;
            default:                   take = 1'b0;
        endcase
        upc_next = take ? ctrl.target : upc_reg + 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            upc_reg <= bse_pkg::UA_LOAD;
        end else begin
            upc_reg <= upc_next;
        end
    end

endmodule

>>> sv/bse_datapath.sv
// List memory, bubble register, counters and result register.
`timescale 1ns / 1ps
module bse_datapath (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  bse_pkg::ctrl_word_t               ctrl,
    output bse_pkg::dp_flags_t                flags,
    input  logic                              s_valid,
    input  logic signed [bse_pkg::DATA_W-1:0] s_element,
    input  logic                              s_final_req,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic signed [bse_pkg::DATA_W-1:0] m_sorted_value,
    output logic                              m_end_of_list,
    output logic                              m_dropped
);

    localparam int CW = bse_pkg::CNT_W;
    localparam int IW = bse_pkg::IDX_W;

    logic signed [bse_pkg::DATA_W-1:0] mem [bse_pkg::DEPTH];
    logic signed [bse_pkg::DATA_W-1:0] rdata_reg;
    logic signed [bse_pkg::DATA_W-1:0] hold_reg, hold_next;
    logic [CW-1:0] fill_reg, fill_next;
    logic [CW-1:0] k_reg, k_next;
    logic [CW-1:0] pass_reg, pass_next;
    logic          ovf_reg, ovf_next;
    logic          mvalid_reg, mvalid_next;
    logic signed [bse_pkg::DATA_W-1:0] mval_reg, mval_next;
    logic          mend_reg, mend_next;
    logic          mdrop_reg, mdrop_next;

    logic [CW:0]   k1, k2, pass1, n_ext;
    logic          s_acc, has_room, gt;
    logic [IW-1:0] rd_addr, wr_addr;
    logic          wr_en;
    logic signed [bse_pkg::DATA_W-1:0] wr_data;

    assign s_acc    = s_valid && ctrl.in_ready;
    assign has_room = fill_reg < CW'(bse_pkg::DEPTH);
    assign n_ext    = {1'b0, fill_reg};
    assign k1       = {1'b0, k_reg} + (CW+1)'(1);
    assign k2       = {1'b0, k_reg} + (CW+1)'(2);
    assign pass1    = {1'b0, pass_reg} + (CW+1)'(1);
    assign gt       = hold_reg > rdata_reg;

    assign flags.acc_final  = s_acc && s_final_req;
    assign flags.m_acc      = mvalid_reg && m_ready;
    assign flags.k1_ge_n    = k1 >= n_ext;
    assign flags.k2_lt_n    = k2 < n_ext;
    assign flags.pass1_lt_n = pass1 < n_ext;
    assign flags.k_lt_n     = k_reg < fill_reg;

    always_comb begin
        case (ctrl.rd_sel)
            bse_pkg::RD_K1: rd_addr = k1[IW-1:0];
            bse_pkg::RD_K2: rd_addr = k2[IW-1:0];
            default:        rd_addr = '0;
        endcase
    end

    always_comb begin
        fill_next   = fill_reg;
        k_next      = k_reg;
        pass_next   = pass_reg;
        ovf_next    = ovf_reg;
        hold_next   = hold_reg;
        mvalid_next = mvalid_reg && !m_ready;
        mval_next   = mval_reg;
        mend_next   = mend_reg;
        mdrop_next  = mdrop_reg;
        wr_en       = 1'b0;
        wr_addr     = k_reg[IW-1:0];
        wr_data     = hold_reg;
        unique case (ctrl.act)
            bse_pkg::ACT_NONE: begin
            end
            bse_pkg::ACT_LOAD: begin
                wr_addr = fill_reg[IW-1:0];
                wr_data = s_element;
                if (s_acc && has_room) begin
                    wr_en     = 1'b1;
                    fill_next = fill_reg + 1'b1;
                end
                if (s_acc && !has_room) begin
                    ovf_next = 1'b1;
                end
            end
            bse_pkg::ACT_PASS_CLR: pass_next = '0;
            bse_pkg::ACT_K_CLR:    k_next = '0;
            bse_pkg::ACT_HOLD:     hold_next = rdata_reg;
            bse_pkg::ACT_CMP: begin
                // smaller of the pair stays behind, larger keeps bubbling
                wr_en     = 1'b1;
                wr_data   = gt ? rdata_reg : hold_reg;
                hold_next = gt ? hold_reg : rdata_reg;
                k_next    = k1[CW-1:0];
            end
            bse_pkg::ACT_PASS_END: begin
                wr_en     = 1'b1;
                pass_next = pass1[CW-1:0];
            end
            bse_pkg::ACT_OUT: begin
                mvalid_next = 1'b1;
                mval_next   = rdata_reg;
                mend_next   = k1 == n_ext;
                mdrop_next  = ovf_reg;
                k_next      = k1[CW-1:0];
            end
            bse_pkg::ACT_CLEAR: begin
                fill_next = '0;
                ovf_next  = 1'b0;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (ctrl.rd_en) begin
            rdata_reg <= mem[rd_addr];
        end
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg   <= '0;
            ovf_reg    <= 1'b0;
            mvalid_reg <= 1'b0;
        end else begin
            fill_reg   <= fill_next;
            ovf_reg    <= ovf_next;
            mvalid_reg <= mvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        k_reg     <= k_next;
        pass_reg  <= pass_next;
        hold_reg  <= hold_next;
        mval_reg  <= mval_next;
        mend_reg  <= mend_next;
        mdrop_reg <= mdrop_next;
    end

    assign m_valid        = mvalid_reg;
    assign m_sorted_value = mval_reg;
    assign m_end_of_list  = mend_reg;
    assign m_dropped      = mdrop_reg;

endmodule

>>> sv/bse_checker.sv
// Port-level checks for the bubble sort engine, bound to the top level.
`timescale 1ns / 1ps
`include "bubble_sort_engine_defines.svh"
module bse_checker (
    input logic                              aclk,
    input logic                              aresetn,
    input logic                              s_valid,
    input logic                              s_ready,
    input logic                              s_final_req,
    input logic                              m_valid,
    input logic                              m_ready,
    input logic signed [bse_pkg::DATA_W-1:0] m_sorted_value,
    input logic                              m_end_of_list,
    input logic                              m_dropped
);

    `BSE_ASSERT(a_out_hold, aclk, aresetn, m_valid && !m_ready |=> m_valid && $stable(m_sorted_value) && $stable(m_end_of_list) && $stable(m_dropped))
    `BSE_ASSERT(a_no_overlap, aclk, aresetn, !(s_ready && m_valid))
    `BSE_ASSERT(a_mid_list_busy, aclk, aresetn, m_valid && m_ready && !m_end_of_list |=> !s_ready)
    `BSE_ASSERT(a_load_continues, aclk, aresetn, s_valid && s_ready && !s_final_req |=> s_ready)
    `BSE_ASSERT_ALWAYS(a_reset_quiet, aclk, !aresetn |=> !m_valid)

endmodule

bind bubble_sort_engine bse_checker u_bse_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .s_valid        (s_valid),
    .s_ready        (s_ready),
    .s_final_req    (s_final_req),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_sorted_value (m_sorted_value),
    .m_end_of_list  (m_end_of_list),
    .m_dropped      (m_dropped)
);
